// File: hdl/ptbl_pkg.sv
package ptbl_pkg;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_WR_ANGLE = 2'd1,
    OP_WR_SPEED = 2'd2,
    OP_WR_ENTRY = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic CFG_ANGLE_USED = 1'b0;
  localparam logic CFG_SPEED_USED = 1'b1;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_WRITE,
    CMD_SRCH_A,
    CMD_SRCH_S,
    CMD_READ,
    CMD_LOAD_DIV,
    CMD_DIV_STEP,
    CMD_STORE_DIV,
    CMD_FINISH
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic is_query;
    logic zero_query;
    logic srch_done;
    logic read_done;
    logic div_done;
  } status_t;

endpackage

// File: hdl/polar_table_bilinear_lookup_unit.sv
// Polar table bilinear lookup.
// Input channel (in_valid/in_stall) carries one item per transfer: a query
// (opcode 0) or a write of an angle breakpoint, speed breakpoint or table
// entry. A query returns one result on the output channel (out_valid/
// out_stall); writes return nothing. Items are handled one at a time.
// Each item is transferred and then decoded; a write is done at decode. A
// query then searches the angle and the speed breakpoints (one breakpoint
// memory read per cycle), makes the four corner reads on the single table
// port, runs three interpolation divisions on one shared radix-2 divider
// and finishes. A zero-coordinate query goes from decode to the finish step.
// The result is valid from the cycle after the finish step.
// A result waits in the output register while out_stall is high; the next
// item still runs, and only its finish step waits for that transfer.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the counts of
// breakpoints in use; the user must make them only while idle, the block does
// not enforce it. Reset (rst_n low, synchronous) returns both counts to 2 and
// empties the control path; breakpoints and table are undefined until written.
module polar_table_bilinear_lookup_unit #(
  parameter int ANGLE_POINTS = 32,
  parameter int SPEED_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_angle_value,
  input  logic [9:0]  in_speed_value,
  input  logic [4:0]  in_angle_slot,
  input  logic [3:0]  in_speed_slot,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_boat_speed,
  output logic        out_clamped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import ptbl_pkg::*;

  cmd_t       cmd;
  status_t    st;
  logic [1:0] div_sel;

  assign cfg_ready = 1'b1;

  ptbl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .st, .cmd, .div_sel
  );

  ptbl_dp #(.ANGLE_POINTS(ANGLE_POINTS), .SPEED_POINTS(SPEED_POINTS)) u_dp (
    .clk, .rst_n, .cmd, .div_sel, .st,
    .cfg_valid, .cfg_index, .cfg_data,
    .in_opcode, .in_angle_value, .in_speed_value, .in_angle_slot,
    .in_speed_slot, .in_entry_value, .out_boat_speed, .out_clamped
  );
endmodule

// File: hdl/ptbl_ctrl.sv
module ptbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ptbl_pkg::status_t st,
  output ptbl_pkg::cmd_t    cmd,
  output logic [1:0]        div_sel
);
  import ptbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SRCH_A, S_SRCH_S, S_READ, S_LOAD, S_DIV, S_STORE, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       ov_r, ov_nxt;
  logic       out_busy;

  // The output register is still held by a stalled result.
  assign out_busy  = ov_r && out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign div_sel   = sel_r;

  // Command decode per state.
  always_comb begin
    cmd = CMD_NONE;
    unique case (state_r)
      S_IDLE:   cmd = in_valid ? CMD_CAPTURE : CMD_NONE;
      S_DECODE: cmd = st.is_query ? CMD_NONE : CMD_WRITE;
      S_SRCH_A: cmd = CMD_SRCH_A;
      S_SRCH_S: cmd = CMD_SRCH_S;
      S_READ:   cmd = CMD_READ;
      S_LOAD:   cmd = CMD_LOAD_DIV;
      S_DIV:    cmd = CMD_DIV_STEP;
      S_STORE:  cmd = CMD_STORE_DIV;
      S_FIN:    cmd = out_busy ? CMD_NONE : CMD_FINISH;
      default:  cmd = CMD_NONE;
    endcase
  end

  // Sequencing: a nonzero query searches both axes, reads four corners, then runs three divisions.
  // The finish step waits while an earlier result is still stalled.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ov_nxt    = out_busy;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (!st.is_query) state_nxt = S_IDLE;
        else if (st.zero_query) state_nxt = S_FIN;
        else state_nxt = S_SRCH_A;
      end
      S_SRCH_A: if (st.srch_done) state_nxt = S_SRCH_S;
      S_SRCH_S: if (st.srch_done) state_nxt = S_READ;
      S_READ:   if (st.read_done) begin
        state_nxt = S_LOAD;
        sel_nxt   = 2'd0;
      end
      S_LOAD:   state_nxt = S_DIV;
      S_DIV:    if (st.div_done) state_nxt = S_STORE;
      S_STORE:  begin
        if (sel_r == 2'd2) state_nxt = S_FIN;
        else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_LOAD;
        end
      end
      S_FIN:    if (!out_busy) begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// File: hdl/ptbl_dp.sv
module ptbl_dp #(
  parameter int ANGLE_POINTS = 32,
  parameter int SPEED_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptbl_pkg::cmd_t    cmd,
  input  logic [1:0]        div_sel,
  output ptbl_pkg::status_t st,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_angle_value,
  input  logic [9:0]        in_speed_value,
  input  logic [4:0]        in_angle_slot,
  input  logic [3:0]        in_speed_slot,
  input  logic [15:0]       in_entry_value,
  output logic [15:0]       out_boat_speed,
  output logic              out_clamped
);
  import ptbl_pkg::*;

  localparam int AW = $clog2(ANGLE_POINTS);
  localparam int SW = $clog2(SPEED_POINTS);
  localparam int TD = ANGLE_POINTS * (1 << SW);

  // Breakpoint and table memories.
  logic [7:0]  abp_mem [ANGLE_POINTS];
  logic [9:0]  sbp_mem [SPEED_POINTS];
  logic [15:0] tbl_mem [TD];

  logic [5:0]  na_reg_r;
  logic [4:0]  ns_reg_r;
  logic [1:0]  op_r;
  logic [7:0]  av_r;
  logic [9:0]  sv_r;
  logic [4:0]  as_r;
  logic [3:0]  ss_r;
  logic [15:0] ev_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_reg_r <= 6'd2;
      ns_reg_r <= 5'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ANGLE_USED) na_reg_r <= cfg_data;
      else ns_reg_r <= cfg_data[4:0];
    end
  end

  // Clamped counts in use.
  logic [6:0] na, ns;
  always_comb begin
    if (na_reg_r == 6'd0) na = 7'd1;
    else if (7'(na_reg_r) > 7'(ANGLE_POINTS)) na = 7'(ANGLE_POINTS);
    else na = 7'(na_reg_r);
    if (ns_reg_r == 5'd0) ns = 7'd1;
    else if (7'(ns_reg_r) > 7'(SPEED_POINTS)) ns = 7'(SPEED_POINTS);
    else ns = 7'(ns_reg_r);
  end

  // Item capture and writes.
  always_ff @(posedge clk) begin
    if (cmd == CMD_CAPTURE) begin
      op_r <= in_opcode;
      av_r <= in_angle_value;
      sv_r <= in_speed_value;
      as_r <= in_angle_slot;
      ss_r <= in_speed_slot;
      ev_r <= in_entry_value;
    end
  end

  logic a_ok, s_ok;
  assign a_ok = 32'(as_r) < ANGLE_POINTS;
  assign s_ok = 32'(ss_r) < SPEED_POINTS;

  always_ff @(posedge clk) begin
    if (cmd == CMD_WRITE) begin
      if (op_r == OP_WR_ANGLE && a_ok) abp_mem[AW'(as_r)] <= av_r;
      if (op_r == OP_WR_SPEED && s_ok) sbp_mem[SW'(ss_r)] <= sv_r;
      if (op_r == OP_WR_ENTRY && a_ok && s_ok)
        tbl_mem[{AW'(as_r), SW'(ss_r)}] <= ev_r;
    end
  end

  assign st.is_query   = (op_r == OP_QUERY);
  assign st.zero_query = (av_r == 8'd0) || (sv_r == 10'd0);

  // Breakpoint search: one breakpoint read per cycle, registered.
  logic [6:0]  idx_r;
  logic        rd_pend_r;
  logic [9:0]  bp_q_r, prev_r;
  logic        found_r;
  logic [9:0]  coord;
  logic [6:0]  lim;
  logic [AW-1:0] alo_r, ahi_r;
  logic [SW-1:0] slo_r, shi_r;
  logic [9:0]  anum_r, aden_r, snum_r, sden_r;
  logic        aclmp_r, sclmp_r;

  assign coord = (cmd == CMD_SRCH_A) ? 10'(av_r) : sv_r;
  assign lim   = (cmd == CMD_SRCH_A) ? na : ns;

  always_ff @(posedge clk) begin
    if (cmd == CMD_SRCH_A) bp_q_r <= 10'(abp_mem[idx_r[AW-1:0]]);
    else bp_q_r <= sbp_mem[idx_r[SW-1:0] ];
  end

  // A search ends at the first breakpoint at or above, or past the last in use.
  logic srch_hit, srch_end;
  assign srch_hit = rd_pend_r && (coord <= bp_q_r);
  assign srch_end = rd_pend_r && !srch_hit && (idx_r == lim);
  assign st.srch_done = found_r;

  logic [6:0] cur;
  assign cur = idx_r - 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 7'd0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd == CMD_SRCH_A || cmd == CMD_SRCH_S) begin
      if (found_r) begin
        found_r   <= 1'b0;
        idx_r     <= 7'd0;
        rd_pend_r <= 1'b0;
      end else if (srch_hit || srch_end) begin
        found_r <= 1'b1;
        if (cmd == CMD_SRCH_A) begin
          if (srch_end) begin
            alo_r <= AW'(lim - 7'd1); ahi_r <= AW'(lim - 7'd1);
            anum_r <= 10'd0; aden_r <= 10'd1; aclmp_r <= 1'b1;
          end else if (cur == 7'd0) begin
            alo_r <= '0; ahi_r <= '0;
            anum_r <= 10'd0; aden_r <= 10'd1; aclmp_r <= coord < bp_q_r;
          end else begin
            alo_r <= AW'(cur - 7'd1); ahi_r <= AW'(cur);
            anum_r <= coord - prev_r; aden_r <= bp_q_r - prev_r; aclmp_r <= 1'b0;
          end
        end else begin
          if (srch_end) begin
            slo_r <= SW'(lim - 7'd1); shi_r <= SW'(lim - 7'd1);
            snum_r <= 10'd0; sden_r <= 10'd1; sclmp_r <= 1'b1;
          end else if (cur == 7'd0) begin
            slo_r <= '0; shi_r <= '0;
            snum_r <= 10'd0; sden_r <= 10'd1; sclmp_r <= coord < bp_q_r;
          end else begin
            slo_r <= SW'(cur - 7'd1); shi_r <= SW'(cur);
            snum_r <= coord - prev_r; sden_r <= bp_q_r - prev_r; sclmp_r <= 1'b0;
          end
        end
      end else begin
        if (rd_pend_r) prev_r <= bp_q_r;
        rd_pend_r <= 1'b1;
        idx_r     <= idx_r + 7'd1;
      end
    end
  end

  // Corner reads: one table read per cycle.
  logic [2:0]  rc_r;
  logic [15:0] tq_r;
  logic [15:0] e_r [4];
  logic [AW-1:0] rrow;
  logic [SW-1:0] rcol;
  assign rrow = rc_r[0] ? ahi_r : alo_r;
  assign rcol = rc_r[1] ? shi_r : slo_r;
  assign st.read_done = (cmd == CMD_READ) && (rc_r == 3'd4);

  always_ff @(posedge clk) begin
    tq_r <= tbl_mem[{rrow, rcol}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rc_r <= 3'd0;
    else if (cmd == CMD_READ) begin
      if (rc_r == 3'd4) rc_r <= 3'd0;
      else rc_r <= rc_r + 3'd1;
      if (rc_r != 3'd0) e_r[rc_r[1:0] - 2'd1] <= tq_r;
    end
  end

  // Shared restoring divider for (b - a) * num / den, sign-magnitude.
  logic [25:0] dividend_r;
  logic [9:0]  den_r;
  logic [10:0] rem_r;
  logic [25:0] quo_r;
  logic        neg_r;
  logic [4:0]  dcnt_r;
  logic [16:0] s1_r, s2_r;
  logic [16:0] base_r;
  logic [16:0] ea, eb;
  logic [9:0]  mnum, mden;
  logic [16:0] diff, mag;
  logic [11:0] trial;

  always_comb begin
    case (div_sel)
      2'd0:    begin ea = 17'(e_r[0]); eb = 17'(e_r[1]); mnum = anum_r; mden = aden_r; end
      2'd1:    begin ea = 17'(e_r[2]); eb = 17'(e_r[3]); mnum = anum_r; mden = aden_r; end
      default: begin ea = s1_r; eb = s2_r; mnum = snum_r; mden = sden_r; end
    endcase
    diff = eb - ea;
    mag  = diff[16] ? (~diff + 17'd1) : diff;
  end

  assign trial = {rem_r, dividend_r[25]} - {2'b0, den_r};
  assign st.div_done = (cmd == CMD_DIV_STEP) && (dcnt_r == 5'd0);

  // Quotient bits: 26 steps, one per cycle.
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD_DIV) begin
      dividend_r <= 26'(mag[15:0]) * 26'(mnum);
      den_r      <= mden;
      rem_r      <= '0;
      quo_r      <= '0;
      neg_r      <= diff[16];
      base_r     <= ea;
      dcnt_r     <= 5'd26;
    end else if (cmd == CMD_DIV_STEP && dcnt_r != 5'd0) begin
      if (!trial[11]) begin
        rem_r <= trial[10:0];
        quo_r <= {quo_r[24:0], 1'b1};
      end else begin
        rem_r <= {rem_r[9:0], dividend_r[25]};
        quo_r <= {quo_r[24:0], 1'b0};
      end
      dividend_r <= {dividend_r[24:0], 1'b0};
      dcnt_r     <= dcnt_r - 5'd1;
    end
  end

  logic [16:0] lres;
  assign lres = neg_r ? (base_r - quo_r[16:0]) : (base_r + quo_r[16:0]);

  always_ff @(posedge clk) begin
    if (cmd == CMD_STORE_DIV) begin
      if (div_sel == 2'd0) s1_r <= lres;
      else if (div_sel == 2'd1) s2_r <= lres;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd == CMD_FINISH) begin
      if (st.zero_query) begin
        out_boat_speed <= 16'd0;
        out_clamped    <= 1'b0;
      end else begin
        out_boat_speed <= lres[15:0];
        out_clamped    <= aclmp_r | sclmp_r;
      end
    end
  end
endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptbl_pkg::*;

  localparam int N_ANGLE = 32;
  localparam int N_SPEED = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [15:0] boat_speed;
    logic        clamped;
  } speed_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_angle_value;
  logic [9:0]  in_speed_value;
  logic [4:0]  in_angle_slot;
  logic [3:0]  in_speed_slot;
  logic [15:0] in_entry_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_boat_speed;
  logic        out_clamped;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [5:0]  cfg_data;

  // Shadow copy of the block's tables and counts.
  logic [7:0]  angle_bp [N_ANGLE];
  logic [9:0]  speed_bp [N_SPEED];
  logic [15:0] speed_tbl [N_ANGLE*N_SPEED];
  logic [5:0]  angle_used_reg;
  logic [4:0]  speed_used_reg;

  speed_result_t expected_speeds[$];
  int mismatches;
  int idle_cycles;
  int burst_left;
  int hold_cycles;
  int stall_mode;
  int mode_cycles;

  polar_table_bilinear_lookup_unit dut (.*);

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clip_count(int r, int lim);
    if (r < 1) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  // Finds the first breakpoint at or above v and the interval around it.
  function automatic void bracket(input int v, input int bp[N_ANGLE], input int n,
                                  output int lo, output int hi, output longint num,
                                  output longint den, output logic oor);
    int i;
    i = 0;
    while (i < n && v > bp[i]) i++;
    num = 0;
    den = 1;
    oor = 1'b0;
    if (i >= n) begin
      lo = n - 1;
      hi = n - 1;
      oor = 1'b1;
    end else if (i == 0) begin
      lo = 0;
      hi = 0;
      oor = (v < bp[0]);
    end else begin
      lo = i - 1;
      hi = i;
      num = v - bp[i-1];
      den = bp[i] - bp[i-1];
    end
  endfunction

  function automatic longint blend(longint a, longint b, longint num, longint den);
    if (den <= 0) return a;
    return a + ((b - a) * num) / den;
  endfunction

  function automatic speed_result_t predict_boat_speed(int av, int sv);
    speed_result_t r;
    int abp[N_ANGLE];
    int sbp[N_ANGLE];
    int na, ns, alo, ahi, slo, shi;
    longint anum, aden, snum, sden, s1, s2, s;
    logic aoor, soor;
    r.boat_speed = '0;
    r.clamped = 1'b0;
    if (av == 0 || sv == 0) return r;
    na = clip_count(angle_used_reg, N_ANGLE);
    ns = clip_count(speed_used_reg, N_SPEED);
    foreach (abp[i]) abp[i] = angle_bp[i];
    foreach (sbp[i]) sbp[i] = (i < N_SPEED) ? speed_bp[i] : 0;
    bracket(av, abp, na, alo, ahi, anum, aden, aoor);
    bracket(sv, sbp, ns, slo, shi, snum, sden, soor);
    s1 = blend(speed_tbl[alo*N_SPEED+slo], speed_tbl[ahi*N_SPEED+slo], anum, aden);
    s2 = blend(speed_tbl[alo*N_SPEED+shi], speed_tbl[ahi*N_SPEED+shi], anum, aden);
    s = blend(s1, s2, snum, sden);
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    r.boat_speed = s[15:0];
    r.clamped = aoor | soor;
    return r;
  endfunction

  // Sends one item, updates the shadow state on transfer, then maybe idles.
  task automatic send_item(opcode_t op, int av, int sv, int aslot, int sslot, int ev);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_angle_value <= 8'(av);
    in_speed_value <= 10'(sv);
    in_angle_slot <= 5'(aslot);
    in_speed_slot <= 4'(sslot);
    in_entry_value <= 16'(ev);
    do @(posedge clk); while (in_stall);
    case (op)
      OP_QUERY: expected_speeds.push_back(predict_boat_speed(av & 8'hFF, sv & 10'h3FF));
      OP_WR_ANGLE: angle_bp[aslot] = 8'(av);
      OP_WR_SPEED: speed_bp[sslot] = 10'(sv);
      OP_WR_ENTRY: speed_tbl[aslot*N_SPEED+sslot] = 16'(ev);
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic query(int av, int sv);
    send_item(OP_QUERY, av, sv, $urandom_range(0, 31), $urandom_range(0, 15),
              $urandom_range(0, 65535));
  endtask

  // Stops sending, waits for every expected result, then drains so pending writes finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ANGLE_USED) angle_used_reg = val;
    else speed_used_reg = val[4:0];
    @(posedge clk);
  endtask

  task automatic set_counts(int na, int ns);
    write_reg(CFG_ANGLE_USED, 6'(na));
    write_reg(CFG_SPEED_USED, 6'(ns));
  endtask

  // Fills every breakpoint and table entry so that no query reads stale data.
  task automatic test_fill_tables();
    for (int i = 0; i < N_ANGLE; i++)
      send_item(OP_WR_ANGLE, 10 + i*5, $urandom_range(0, 1023), i, $urandom_range(0, 15), 0);
    for (int j = 0; j < N_SPEED; j++)
      send_item(OP_WR_SPEED, $urandom_range(0, 255), 30 + j*60, $urandom_range(0, 31), j, 0);
    for (int k = 0; k < N_ANGLE*N_SPEED; k++)
      send_item(OP_WR_ENTRY, $urandom_range(0, 255), $urandom_range(0, 1023),
                k / N_SPEED, k % N_SPEED, $urandom_range(0, 65535));
  endtask

  // Zero coordinates, edges, exact breakpoints and extreme entries.
  task automatic test_directed();
    set_counts(N_ANGLE, N_SPEED);
    query(0, 500);
    query(90, 0);
    query(0, 0);
    query(1, 1);
    query(10, 30);
    query(255, 1023);
    query(165, 930);
    query(166, 931);
    query(12, 47);
    query(1, 500);
    query(100, 1023);
    send_item(OP_WR_ENTRY, 0, 0, 0, 0, 16'hFFFF);
    send_item(OP_WR_ENTRY, 0, 0, 1, 0, 16'h0000);
    send_item(OP_WR_ENTRY, 0, 0, 0, 1, 16'h0000);
    send_item(OP_WR_ENTRY, 0, 0, 1, 1, 16'hFFFF);
    query(10, 30);
    query(13, 50);
    query(14, 89);
    query(15, 90);
  endtask

  // Counts at and beyond their limits.
  task automatic test_count_limits();
    set_counts(1, 1);
    query(5, 10);
    query(200, 900);
    set_counts(0, 0);
    query(10, 30);
    query(77, 333);
    set_counts(63, 31);
    query(180, 1000);
    query(40, 200);
    set_counts(33, 17);
    query(255, 1023);
  endtask

  // Mostly queries with random content, some writes that also unsort tables.
  task automatic random_items(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        query(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 255),
              ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 1023));
      else if (r < 77)
        send_item(OP_WR_ANGLE, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 65535));
      else if (r < 84)
        send_item(OP_WR_SPEED, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 65535));
      else
        send_item(OP_WR_ENTRY, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 65535));
    end
  endtask

  task automatic test_random();
    set_counts(N_ANGLE, N_SPEED);
    random_items(150);
    set_counts(2, 2);
    random_items(100);
    set_counts(1, 16);
    random_items(80);
    set_counts(32, 1);
    random_items(80);
    set_counts($urandom_range(0, 63), $urandom_range(0, 31));
    random_items(80);
  endtask

  // Receiver holds off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    set_counts(N_ANGLE, N_SPEED);
    hold_cycles = 600;
    burst_left = 20;
    for (int n = 0; n < 12; n++) query($urandom_range(1, 255), $urandom_range(1, 1023));
  endtask

  // Receiver stall pattern, with a counted long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_cycles <= $urandom_range(20, 120);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_speeds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: boat_speed %0d clamped %0b", out_boat_speed, out_clamped);
      end else begin
        if (out_boat_speed !== expected_speeds[0].boat_speed ||
            out_clamped !== expected_speeds[0].clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: boat_speed exp %0d got %0d, clamped exp %0b got %0b",
                     expected_speeds[0].boat_speed, out_boat_speed,
                     expected_speeds[0].clamped, out_clamped);
        end
        void'(expected_speeds.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("polar_table_bilinear_lookup_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_QUERY;
    in_angle_value = '0;
    in_speed_value = '0;
    in_angle_slot = '0;
    in_speed_slot = '0;
    in_entry_value = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ANGLE_USED;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_mode = 0;
    mode_cycles = 0;
    angle_used_reg = 6'd2;
    speed_used_reg = 5'd2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_tables();
    test_directed();
    test_count_limits();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0 && expected_speeds.size() == 0)
      $display("polar_table_bilinear_lookup_unit verification clean");
    else
      $display("polar_table_bilinear_lookup_unit verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ptbl_pkg.sv
hdl/ptbl_ctrl.sv
hdl/ptbl_dp.sv
hdl/polar_table_bilinear_lookup_unit.sv
dv/tb.sv
